// File: sv/ardq_pkg.sv
`timescale 1ns / 1ps

package ardq_pkg;

  // Command codes carried by each input item.
  localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [1:0] CMD_PUSH_BACK  = 2'd1;
  localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [1:0] CMD_POP_BACK   = 2'd3;

  // Status codes returned with each result item.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NO_FRONT  = 2'd2;
  localparam logic [1:0] ST_FULL_BACK = 2'd3;

  // Fixed widths of the channel fields.
  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 5;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic cap;   // capture the accepted item and start the memory read
    logic exec;  // apply the item and load the result register
  } ctl_t;

endpackage

// File: sv/ardq_ctrl.sv
`timescale 1ns / 1ps

module ardq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  output ardq_pkg::ctl_t ctl
);
  import ardq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_FIN
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   fire;

  assign in_stall  = !rst_n || (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  // The result register may be loaded when it is empty or being drained.
  assign fire = (state_r == S_FIN) && (!out_valid_r || !out_stall);

  always_comb begin
    ctl.cap       = 1'b0;
    ctl.exec      = 1'b0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          ctl.cap   = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (fire) begin
          ctl.exec      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_cap_then_fin: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.cap |=> state_r == S_FIN)
    else $error("captured item did not move to the finish state");

  a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.exec |=> out_valid_r)
    else $error("executed item produced no result");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |-> !ctl.exec)
    else $error("result register loaded while a stalled result waits");

endmodule

// File: sv/ardq_dpath.sv
`timescale 1ns / 1ps

module ardq_dpath #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ardq_pkg::ctl_t                  ctl,
  input  logic [ardq_pkg::CMD_W-1:0]      in_cmd,
  input  logic signed [ardq_pkg::VALUE_W-1:0] in_value,
  output logic [ardq_pkg::STATUS_W-1:0]   out_status,
  output logic signed [ardq_pkg::VALUE_W-1:0] out_removed,
  output logic [ardq_pkg::COUNT_W-1:0]    out_count
);
  import ardq_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int VW = (DATA_WIDTH > VALUE_W) ? DATA_WIDTH : VALUE_W;
  localparam int CW = (AW + 1 > COUNT_W) ? AW + 1 : COUNT_W;

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0]         head_r, head_nxt;
  logic [AW-1:0]         tail_r, tail_nxt;
  logic                  empty_r, empty_nxt;
  logic [CMD_W-1:0]      cmd_r;
  logic [DATA_WIDTH-1:0] wd_r;
  logic [DATA_WIDTH-1:0] rd_q;

  logic [STATUS_W-1:0]       status_r;
  logic signed [VALUE_W-1:0] removed_r;
  logic [COUNT_W-1:0]        count_r;

  logic [AW-1:0]         raddr;
  logic [AW-1:0]         waddr;
  logic                  we;
  logic                  pop_ok;
  logic [STATUS_W-1:0]   st;
  logic [VW-1:0]         val_ext;
  logic signed [VW-1:0]  rd_ext;
  logic [CW-1:0]         cnt_w;

  // Incoming values keep only their low DATA_WIDTH bits.
  assign val_ext = VW'($unsigned(in_value));
  // Popped elements are sign-extended back to the field width.
  assign rd_ext  = VW'($signed(rd_q));

  assign raddr = (in_cmd == CMD_POP_FRONT) ? head_r : tail_r;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    empty_nxt = empty_r;
    st        = ST_OK;
    pop_ok    = 1'b0;
    we        = 1'b0;
    waddr     = head_r;
    unique case (cmd_r) inside
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (empty_r) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          empty_nxt = 1'b0;
          we        = 1'b1;
          waddr     = '0;
        end else if (cmd_r == CMD_PUSH_FRONT) begin
          if (head_r == '0) begin
            st = ST_NO_FRONT;
          end else begin
            head_nxt = head_r - AW'(1);
            we       = 1'b1;
            waddr    = head_r - AW'(1);
          end
        end else begin
          if (tail_r == AW'(DEPTH - 1)) begin
            st = ST_FULL_BACK;
          end else begin
            tail_nxt = tail_r + AW'(1);
            we       = 1'b1;
            waddr    = tail_r + AW'(1);
          end
        end
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (empty_r) begin
          st = ST_EMPTY;
        end else begin
          pop_ok = 1'b1;
          if (head_r == tail_r) begin
            head_nxt  = '0;
            tail_nxt  = '0;
            empty_nxt = 1'b1;
          end else if (cmd_r == CMD_POP_FRONT) begin
            head_nxt = head_r + AW'(1);
          end else begin
            tail_nxt = tail_r - AW'(1);
          end
        end
      end
      default: st = ST_OK;
    endcase
  end

  assign cnt_w = empty_nxt ? '0 : (CW'(tail_nxt) - CW'(head_nxt) + CW'(1));

  // Element store; the read for a pop is issued when the item is accepted.
  always_ff @(posedge clk) begin
    if (ctl.exec && we) begin
      mem[waddr] <= wd_r;
    end
    if (ctl.cap) begin
      rd_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      cmd_r <= in_cmd;
      wd_r  <= val_ext[DATA_WIDTH-1:0];
    end
    if (ctl.exec) begin
      status_r  <= st;
      removed_r <= pop_ok ? rd_ext[VALUE_W-1:0] : '0;
      count_r   <= cnt_w[COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
    end else if (ctl.exec) begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      empty_r <= empty_nxt;
    end
  end

  assign out_status  = status_r;
  assign out_removed = removed_r;
  assign out_count   = count_r;

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    !empty_r |-> head_r <= tail_r)
    else $error("head index passed tail index");

  a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
    empty_r |-> (head_r == '0) && (tail_r == '0))
    else $error("empty deque with nonzero indices");

  a_idx_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(ctl.exec) |-> $stable(head_r) && $stable(tail_r) && $stable(empty_r))
    else $error("indices changed without an executed item");

endmodule

// File: sv/array_double_ended_queue.sv
// Linear, non-wrapping double-ended queue held in a DEPTH-entry array.
// Input channel: in_valid/in_stall with in_cmd (push front, push back,
// pop front, pop back) and in_value, the element to push. Result channel:
// out_valid/out_stall with out_status, out_removed (the popped element,
// sign-extended, or zero) and out_count, the element count after the item.
// Every accepted item gives exactly one result item.
// An item is taken in the idle state and the element store is read as
// it is captured; the finish state then applies the item and loads the
// result register, which raises out_valid. The block holds one item at
// a time: a new item is taken only after the previous one has passed
// the registered store read and the update step.
// While the receiver stalls, the result stays in the output register; one
// further item may be accepted, and it waits in the update step until the
// register is drained.
// Synchronous reset empties the queue and clears any result in flight;
// in_stall is high during reset. No clearing pass is needed.
`timescale 1ns / 1ps

module array_double_ended_queue #(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ardq_pkg::CMD_W-1:0]          in_cmd,
  input  logic signed [ardq_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ardq_pkg::STATUS_W-1:0]       out_status,
  output logic signed [ardq_pkg::VALUE_W-1:0] out_removed,
  output logic [ardq_pkg::COUNT_W-1:0]        out_count
);
  import ardq_pkg::*;

  ctl_t ctl;

  ardq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl)
  );

  ardq_dpath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (ctl),
    .in_cmd      (in_cmd),
    .in_value    (in_value),
    .out_status  (out_status),
    .out_removed (out_removed),
    .out_count   (out_count)
  );

endmodule
